// ===== src/apid_pkg.sv =====
package apid_pkg;

  localparam int WIN_BITS               = 4;
  localparam int WINDOW_LEN             = 1 << WIN_BITS;
  localparam int OUTPUT_LIMIT           = 9600;
  localparam int RATE_LIMIT             = 16384;
  localparam int AILERON_OF_THROTTLE_Q8 = 0;
  localparam int HALF_PI_Q12            = 6434;

  localparam int ANGLE_W   = 15;
  localparam int RATE_W    = 16;
  localparam int THR_W     = 14;
  localparam int CMD_W     = 15;
  localparam int GAIN_W    = 16;
  localparam int COMP_W    = 15;
  localparam int WEIGHT_W  = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam int S_FIELDS_W = 4 * ANGLE_W + RATE_W + THR_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((2 * CMD_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLL_GAIN        = 3'd0,
    REG_PITCH_GAIN       = 3'd1,
    REG_PITCH_ROLL_COMP  = 3'd2,
    REG_OUTER_RATE_GAIN  = 3'd3,
    REG_RATE_P_GAIN      = 3'd4,
    REG_RATE_I_GAIN      = 3'd5,
    REG_RATE_D_GAIN      = 3'd6,
    REG_RATE_MODE_WEIGHT = 3'd7
  } reg_idx_e;

  typedef enum logic [0:0] {
    CS_IDLE,
    CS_RUN
  } ctrl_state_e;

  typedef enum logic [3:0] {
    ST_STD_A,
    ST_STD_B,
    ST_OUTER,
    ST_RATE,
    ST_QERR,
    ST_WIN,
    ST_KI,
    ST_PG,
    ST_KP_LO,
    ST_KP_HI,
    ST_KP_SUM,
    ST_RATEC,
    ST_BL_A,
    ST_BL_B,
    ST_DONE
  } step_e;

  typedef struct packed {
    logic  load;
    logic  run;
    step_e step;
    logic  out_load;
  } dp_cmd_t;

endpackage

// ===== src/apid_ctrl.sv =====
module apid_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output apid_pkg::dp_cmd_t cmd_o
);
  import apid_pkg::*;

  ctrl_state_e state_q, state_d;
  step_e       step_q, step_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      step_q      <= ST_STD_A;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    s_ready_o      = 1'b0;
    cmd_o          = '0;
    cmd_o.step     = step_q;
    case (state_q)
      CS_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_RUN;
          step_d     = ST_STD_A;
        end
      end
      CS_RUN: begin
        cmd_o.run = 1'b1;
        if (step_q == ST_DONE) begin
          if (!out_valid_q || m_ready_i) begin
            cmd_o.out_load = 1'b1;
            state_d        = CS_IDLE;
          end
        end else begin
          step_d = step_e'(step_q + 4'd1);
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
    out_valid_d = cmd_o.out_load | (out_valid_q & ~m_ready_i);
  end

  assign m_valid_o = out_valid_q;

endmodule

// ===== src/apid_dp.sv =====
module apid_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  apid_pkg::dp_cmd_t                 cmd_i,
  input  logic [apid_pkg::S_FIELDS_W-1:0]   s_data_i,
  input  logic                              cfg_we_i,
  input  logic [apid_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [apid_pkg::CFG_W-1:0]        cfg_data_i,
  output logic [apid_pkg::M_DATA_W-1:0]     m_data_o
);
  import apid_pkg::*;

  localparam int Q12     = 12;
  localparam int Q8      = 8;
  localparam int E_W     = 14;
  localparam int DD_W    = RATE_W + 1;
  localparam int P_W     = 22;
  localparam int SAT_W   = 16;
  localparam int WS_W    = RATE_W + 1 + WIN_BITS;
  localparam int INNER_W = 34 + WIN_BITS;
  localparam int LO_W    = 20;
  localparam int HI_W    = INNER_W - LO_W;
  localparam int A_W     = GAIN_W + 1;
  localparam int B_W     = (WS_W + 2 > P_W + 1) ? WS_W + 2 : P_W + 1;
  localparam int PROD_W  = A_W + B_W;
  localparam int ACC_W   = INNER_W + GAIN_W + 2;

  localparam logic signed [B_W-1:0]    AOT_B      = B_W'(AILERON_OF_THROTTLE_Q8);
  localparam logic [WEIGHT_W-1:0]      WEIGHT_ONE = WEIGHT_W'(256);

  function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W-1:0] x,
                                                  input int lim);
    logic signed [ACC_W-1:0] l;
    l = ACC_W'(lim);
    if (x > l) begin
      return l;
    end else if (x < -l) begin
      return -l;
    end else begin
      return x;
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] rnd_sh(input logic signed [ACC_W-1:0] x,
                                                     input int k);
    logic signed [ACC_W-1:0] t;
    t = x + (ACC_W'(1) <<< (k - 1));
    return t >>> k;
  endfunction

  logic signed [GAIN_W-1:0]   roll_gain_q, pitch_gain_q, outer_q, kp_q, ki_q, kd_q;
  logic [COMP_W-1:0]          comp_q;
  logic [WEIGHT_W-1:0]        weight_q;

  logic signed [RATE_W-1:0]   win_q [WINDOW_LEN];
  logic signed [WS_W-1:0]     ws_q;
  logic [WIN_BITS-1:0]        pos_q;
  logic signed [RATE_W-1:0]   prev_rate_q;

  logic signed [RATE_W-1:0]   rate_meas_q;
  logic [THR_W-1:0]           thr_q;
  logic signed [E_W-1:0]      e_q;
  logic [ANGLE_W-1:0]         abs_roll_q;
  logic signed [RATE_W-1:0]   dp_q;
  logic signed [DD_W-1:0]     dd_q;
  logic signed [RATE_W-1:0]   r_q, q_q;
  logic signed [SAT_W-1:0]    stdc_q, ratec_q, elev_q;
  logic signed [P_W-1:0]      p_q;
  logic signed [HI_W-1:0]     hi_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [M_DATA_W-1:0]        m_data_q;

  logic signed [ANGLE_W-1:0]  roll_in, pitch_in, roll_t_in, pitch_t_in;
  logic signed [RATE_W-1:0]   rate_in;
  logic [THR_W-1:0]           thr_in;
  logic signed [E_W-1:0]      e_load;
  logic [ANGLE_W-1:0]         abs_load;
  logic signed [RATE_W-1:0]   dp_load;
  logic signed [DD_W-1:0]     dd_load;
  logic signed [WS_W-1:0]     ws_next;
  logic [WEIGHT_W-1:0]        w_sat, w_inv;
  logic signed [A_W-1:0]      op_a;
  logic signed [B_W-1:0]      op_b;
  logic signed [ACC_W-1:0]    prod_x;
  logic [CMD_W-1:0]           ail_w;

  assign roll_in    = $signed(s_data_i[ANGLE_W-1:0]);
  assign pitch_in   = $signed(s_data_i[2*ANGLE_W-1:ANGLE_W]);
  assign rate_in    = $signed(s_data_i[2*ANGLE_W+RATE_W-1:2*ANGLE_W]);
  assign roll_t_in  = $signed(s_data_i[3*ANGLE_W+RATE_W-1:2*ANGLE_W+RATE_W]);
  assign pitch_t_in = $signed(s_data_i[4*ANGLE_W+RATE_W-1:3*ANGLE_W+RATE_W]);
  assign thr_in     = s_data_i[S_FIELDS_W-1:4*ANGLE_W+RATE_W];

  always_comb begin
    e_load   = E_W'(sat(ACC_W'(roll_in) - ACC_W'(roll_t_in), HALF_PI_Q12));
    abs_load = roll_in[ANGLE_W-1] ? ANGLE_W'(-roll_in) : ANGLE_W'(roll_in);
    dp_load  = RATE_W'(ACC_W'(pitch_t_in) - ACC_W'(pitch_in));
    dd_load  = DD_W'(ACC_W'(rate_in) - ACC_W'(prev_rate_q));
    ws_next  = ws_q - WS_W'(win_q[pos_q]) + WS_W'(q_q);
    w_sat    = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
    w_inv    = WEIGHT_ONE - w_sat;
    prod_x   = ACC_W'(prod_q);
    ail_w    = CMD_W'(rnd_sh(acc_q, Q8));
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (cmd_i.run) begin
      case (cmd_i.step)
        ST_STD_A: begin
          op_a = A_W'(roll_gain_q);
          op_b = B_W'(e_q);
        end
        ST_STD_B: begin
          op_a = $signed({{(A_W-THR_W){1'b0}}, thr_q});
          op_b = AOT_B;
        end
        ST_OUTER: begin
          op_a = A_W'(outer_q);
          op_b = -B_W'(e_q);
        end
        ST_RATE: begin
          op_a = $signed({{(A_W-COMP_W){1'b0}}, comp_q});
          op_b = $signed({{(B_W-ANGLE_W){1'b0}}, abs_roll_q});
        end
        ST_QERR: begin
          op_a = A_W'(kd_q);
          op_b = B_W'(dd_q);
        end
        ST_KI: begin
          op_a = A_W'(ki_q);
          op_b = B_W'(ws_q);
        end
        ST_PG: begin
          op_a = A_W'(pitch_gain_q);
          op_b = B_W'(p_q);
        end
        ST_KP_LO: begin
          op_a = A_W'(kp_q);
          op_b = $signed({{(B_W-LO_W){1'b0}}, acc_q[LO_W-1:0]});
        end
        ST_KP_HI: begin
          op_a = A_W'(kp_q);
          op_b = B_W'(hi_q);
        end
        ST_RATEC: begin
          op_a = $signed({{(A_W-WEIGHT_W){1'b0}}, w_inv});
          op_b = B_W'(stdc_q);
        end
        ST_BL_A: begin
          op_a = $signed({{(A_W-WEIGHT_W){1'b0}}, w_sat});
          op_b = B_W'(ratec_q);
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_gain_q  <= '0;
      pitch_gain_q <= '0;
      comp_q       <= '0;
      outer_q      <= '0;
      kp_q         <= '0;
      ki_q         <= '0;
      kd_q         <= '0;
      weight_q     <= WEIGHT_ONE;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROLL_GAIN:        roll_gain_q  <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_PITCH_GAIN:       pitch_gain_q <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_PITCH_ROLL_COMP:  comp_q       <= cfg_data_i[COMP_W-1:0];
        REG_OUTER_RATE_GAIN:  outer_q      <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_RATE_P_GAIN:      kp_q         <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_RATE_I_GAIN:      ki_q         <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_RATE_D_GAIN:      kd_q         <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_RATE_MODE_WEIGHT: weight_q     <= cfg_data_i[WEIGHT_W-1:0];
        default:              weight_q     <= weight_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
      ws_q        <= '0;
      pos_q       <= '0;
      prev_rate_q <= '0;
    end else begin
      if (cmd_i.load) begin
        prev_rate_q <= rate_in;
      end
      if (cmd_i.run && (cmd_i.step == ST_WIN)) begin
        win_q[pos_q] <= q_q;
        ws_q         <= ws_next;
        pos_q        <= pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    if (cmd_i.load) begin
      rate_meas_q <= rate_in;
      thr_q       <= thr_in;
      e_q         <= e_load;
      abs_roll_q  <= abs_load;
      dp_q        <= dp_load;
      dd_q        <= dd_load;
    end
    if (cmd_i.run) begin
      case (cmd_i.step)
        ST_STD_B: acc_q <= prod_x;
        ST_OUTER: acc_q <= acc_q + (prod_x <<< 4);
        ST_RATE: begin
          stdc_q <= SAT_W'(sat(rnd_sh(acc_q, Q12), OUTPUT_LIMIT));
          r_q    <= RATE_W'(sat(rnd_sh(prod_x, Q8), RATE_LIMIT));
        end
        ST_QERR: begin
          q_q   <= RATE_W'(sat(ACC_W'(rate_meas_q) - ACC_W'(r_q), RATE_LIMIT));
          acc_q <= (ACC_W'(dp_q) <<< Q8) + prod_x;
        end
        ST_WIN: begin
          p_q   <= P_W'(sat(acc_q, HALF_PI_Q12 * 256));
          acc_q <= prod_x <<< WIN_BITS;
        end
        ST_KI:    acc_q <= acc_q + (ACC_W'(q_q) <<< (Q8 + WIN_BITS));
        ST_PG:    acc_q <= acc_q + prod_x;
        ST_KP_LO: begin
          elev_q <= SAT_W'(sat(rnd_sh(prod_x, Q12 + Q8), OUTPUT_LIMIT));
          hi_q   <= $signed(acc_q[INNER_W-1:LO_W]);
        end
        ST_KP_HI:  acc_q <= prod_x;
        ST_KP_SUM: acc_q <= acc_q + (prod_x <<< LO_W);
        ST_RATEC:  ratec_q <= SAT_W'(sat(rnd_sh(acc_q, Q12 + Q8 + WIN_BITS), OUTPUT_LIMIT));
        ST_BL_A:   acc_q <= prod_x;
        ST_BL_B:   acc_q <= acc_q + prod_x;
        default:   acc_q <= acc_q;
      endcase
    end
    if (cmd_i.out_load) begin
      m_data_q <= {{(M_DATA_W-2*CMD_W){1'b0}}, elev_q[CMD_W-1:0], ail_w};
    end
  end

  assign m_data_o = m_data_q;

endmodule

// ===== src/attitude_pid_roll_pitch.sv =====
// Channel   Direction  Word contents
// s_axis    in         roll, pitch, roll rate, roll target, pitch target, throttle
// m_axis    out        aileron and elevator commands
// cfg       in         one register write per cycle with cfg_we_i
//
// An accepted word runs through fourteen steps of one shared 17x23 multiplier and
// an accumulator, then one step that loads the output register. The input is ready
// again in the cycle after the output register loads, so a new word is accepted
// only once the result of the last one has been loaded.
// A result that is not taken holds the finished computation until the output
// register frees, and no new word is accepted meanwhile.
// Reset clears the error window, its sum and position, and the last roll rate.
module attitude_pid_roll_pitch (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // roll_angle, pitch_angle, roll_rate_meas, roll_target, pitch_target, throttle
  input  logic [apid_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // aileron_cmd, elevator_cmd
  output logic [apid_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [apid_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [apid_pkg::CFG_W-1:0]     cfg_data_i
);
  import apid_pkg::*;

  dp_cmd_t cmd;

  apid_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  apid_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .s_data_i   (s_axis_tdata[S_FIELDS_W-1:0]),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .m_data_o   (m_axis_tdata)
  );

endmodule

// ===== src/apid_checker.sv =====
module apid_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [apid_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import apid_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted while a word is being computed");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared one cycle after acceptance");

  a_cmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $signed(m_axis_tdata[CMD_W-1:0]) <= OUTPUT_LIMIT &&
      $signed(m_axis_tdata[CMD_W-1:0]) >= -OUTPUT_LIMIT &&
      $signed(m_axis_tdata[2*CMD_W-1:CMD_W]) <= OUTPUT_LIMIT &&
      $signed(m_axis_tdata[2*CMD_W-1:CMD_W]) >= -OUTPUT_LIMIT &&
      m_axis_tdata[M_DATA_W-1:2*CMD_W] == '0)
    else $error("command outside the output limit");

endmodule

bind attitude_pid_roll_pitch apid_checker u_apid_checker (.*);
